FILE: design/cfa_pkg.sv
// Package for the contiguous fit allocator: widths, codes and payload types.
// No dependencies.
package cfa_pkg;
  localparam int MemUnitsDefault = 128;
  localparam int OwnerW = 8;
  localparam int SizeW  = 8;
  localparam int StatW  = 2;
  localparam int AddrOutW = 7;
  localparam int HoleW  = 7;
  localparam int UsedW  = 8;

  localparam logic [1:0] FitFirst = 2'd0;
  localparam logic [1:0] FitBest  = 2'd1;
  localparam logic [1:0] FitWorst = 2'd2;
  localparam logic [1:0] FitNext  = 2'd3;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic [StatW-1:0] StDone     = 2'd0;
  localparam logic [StatW-1:0] StNoHole   = 2'd1;
  localparam logic [StatW-1:0] StNotFound = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [OwnerW-1:0] owner_id;
    logic [SizeW-1:0]  request_size;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0]    status;
    logic [AddrOutW-1:0] start_address;
    logic [HoleW-1:0]    hole_count;
    logic [UsedW-1:0]    used_units;
  } rsp_t;
endpackage

FILE: design/cfa_if.sv
// Valid/ready channel interface carrying one request or result item.
// Depends on cfa_pkg.
interface cfa_req_if;
  import cfa_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface cfa_rsp_if;
  import cfa_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: design/cfa_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module cfa_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: design/contiguous_fit_allocator_core.sv
// Contiguous fit allocator: owner map in a RAM, request sequencer, result register.
// Depends on cfa_pkg, cfa_if and cfa_ram.
//
// Usage: requests enter on req (operation, owner_id, request_size) by valid/ready;
// each request yields exactly one result item on rsp. The user must write fit_mode
// through cfg_we_i/cfg_wdata_i only while the block is idle; the block itself
// does not enforce this. An item is handled in passes over the owner map, one
// unit per cycle through the map RAM read port: a search pass (first fit, next
// fit and free stop at the first match), for next fit a possible second pass, a
// write pass over the placed run or the freed run, and a hole count pass. An
// item is accepted only once every pass for the previous one is done.
// After reset a clearing pass writes zero to every unit, during which no item
// is accepted. The result is held in an output register; while the receiver
// stalls, one more item is accepted and processed, and then no new item is
// accepted until the held result leaves.
module contiguous_fit_allocator_core
  import cfa_pkg::*;
#(
  parameter int MEM_UNITS = MemUnitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  cfa_req_if.sink     req,
  cfa_rsp_if.source   rsp
);
  localparam int AW = $clog2(MEM_UNITS);
  localparam int CW = AW + 1;

  localparam logic [2:0] SClr  = 3'd0;
  localparam logic [2:0] SIdle = 3'd1;
  localparam logic [2:0] SScan = 3'd2;
  localparam logic [2:0] SWr   = 3'd3;
  localparam logic [2:0] SHole = 3'd4;
  localparam logic [2:0] SOut  = 3'd5;

  logic [2:0] st_q, st_d;
  logic [1:0] mode_q;
  req_t r_q;
  logic [CW-1:0] idx_q, idx_d;      // address issued this cycle
  logic [CW-1:0] pos_q;             // address whose data arrives now
  logic          pv_q;              // pos_q valid
  logic [CW-1:0] run_q, run_d, from_q;
  logic          pass2_q;
  logic          found_q, found_d;
  logic [CW-1:0] pick_q, pick_d, plen_q, plen_d;
  logic [CW-1:0] wend_q;
  logic [CW-1:0] nfp_q, used_q;
  logic [HoleW-1:0] holes_q;
  logic [StatW-1:0] stat_q;
  rsp_t out_q;
  logic out_v_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [OwnerW-1:0] wdata, rdata;

  cfa_ram #(.Width(OwnerW), .Depth(MEM_UNITS)) u_map (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  localparam logic [CW-1:0] Top = CW'(MEM_UNITS);
  logic [CW-1:0] size_c;
  assign size_c = (32'(r_q.request_size) > MEM_UNITS) ? '0 : CW'(r_q.request_size);
  logic bad_alloc;
  assign bad_alloc = (r_q.owner_id == '0) || (r_q.request_size == '0) ||
                     (32'(r_q.request_size) > MEM_UNITS);

  assign req.ready = (st_q == SIdle);
  assign rsp.valid = out_v_q;
  assign rsp.data  = out_q;
  assign raddr = idx_q[AW-1:0];

  // data available for position pos_q (end marker at Top reads as occupied)
  logic free_u, at_end;
  assign at_end = (pos_q == Top);
  assign free_u = !at_end && (rdata == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= FitFirst;
    else if (cfg_we_i) mode_q <= cfg_wdata_i;
  end

  always_comb begin
    st_d = st_q; idx_d = idx_q; run_d = run_q;
    found_d = found_q; pick_d = pick_q; plen_d = plen_q;
    we = 1'b0; waddr = idx_q[AW-1:0]; wdata = '0;
    case (st_q)
      SClr: begin
        we = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == Top - 1'b1) begin st_d = SIdle; idx_d = '0; end
      end
      SScan: begin
        if (idx_q != Top) idx_d = idx_q + 1'b1;
        if (pv_q) begin
          if (r_q.operation == OpFree) begin
            // Owner zero never matches, so a free of it reports not found.
            if (r_q.owner_id != '0 && !at_end && rdata == r_q.owner_id) begin
              found_d = 1'b1; pick_d = pos_q;
            end
          end else if (mode_q == FitNext) begin
            run_d = free_u ? run_q + 1'b1 : '0;
            if (free_u && run_q + 1'b1 >= size_c) begin
              found_d = 1'b1; pick_d = pos_q + 1'b1 - size_c;
            end
          end else begin
            if (free_u) run_d = run_q + 1'b1;
            else begin
              run_d = '0;
              if (run_q >= size_c && run_q != '0) begin
                if (!found_q || (mode_q == FitBest && run_q <= plen_q) ||
                    (mode_q == FitWorst && run_q >= plen_q)) begin
                  found_d = 1'b1; pick_d = pos_q - run_q; plen_d = run_q;
                end
                if (mode_q == FitFirst) found_d = 1'b1;
              end
            end
          end
        end
      end
      SWr: begin
        // allocate writes blindly; free writes only while unit still matches
        if (r_q.operation == OpAlloc) begin
          we = 1'b1; wdata = r_q.owner_id; idx_d = idx_q + 1'b1;
        end else if (pv_q) begin
          if (!at_end && rdata == r_q.owner_id) begin
            we = 1'b1; waddr = pos_q[AW-1:0]; wdata = '0;
          end
        end
        if (idx_q != Top) idx_d = idx_q + 1'b1;
      end
      SHole: begin
        if (idx_q != Top) idx_d = idx_q + 1'b1;
      end
      default: ;
    endcase
  end

  logic prev_free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClr; idx_q <= '0; pv_q <= 1'b0; nfp_q <= '0; used_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      pos_q <= idx_q;
      if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
      case (st_q)
        SClr: begin
          st_q <= st_d; idx_q <= idx_d; pv_q <= 1'b0;
        end
        SIdle: begin
          if (req.valid) begin
            r_q <= req.data;
            st_q <= SScan; pv_q <= 1'b0; run_q <= '0; found_q <= 1'b0;
            pick_q <= '0; plen_q <= '0; pass2_q <= 1'b0;
            idx_q <= (req.data.operation == OpAlloc && mode_q == FitNext) ? nfp_q : '0;
            from_q <= nfp_q;
          end
        end
        SScan: begin
          if (r_q.operation == OpAlloc && bad_alloc) begin
            stat_q <= StNoHole; pick_q <= '0; st_q <= SHole; idx_q <= '0; pv_q <= 1'b0;
          end else if (found_d && (r_q.operation == OpFree || mode_q == FitNext ||
                                   mode_q == FitFirst)) begin
            stat_q <= StDone; pv_q <= 1'b0; st_q <= SWr;
            pick_q <= pick_d; idx_q <= pick_d;
            if (r_q.operation == OpAlloc) begin
              wend_q <= pick_d + size_c;
              used_q <= used_q + size_c;
              if (mode_q == FitNext) nfp_q <= pick_d + size_c;
            end
          end else if (pv_q && at_end) begin
            if (r_q.operation == OpAlloc && mode_q == FitNext && !pass2_q &&
                from_q != '0) begin
              pass2_q <= 1'b1; idx_q <= '0; pv_q <= 1'b0; run_q <= '0;
            end else if (found_d) begin
              stat_q <= StDone; pv_q <= 1'b0; st_q <= SWr; pick_q <= pick_d;
              idx_q <= pick_d; wend_q <= pick_d + size_c; used_q <= used_q + size_c;
            end else begin
              stat_q <= (r_q.operation == OpFree) ? StNotFound : StNoHole;
              pick_q <= '0; st_q <= SHole; idx_q <= '0; pv_q <= 1'b0;
            end
          end else begin
            idx_q <= idx_d; pv_q <= 1'b1;
            run_q <= run_d; found_q <= found_d; pick_q <= pick_d; plen_q <= plen_d;
          end
        end
        SWr: begin
          if (r_q.operation == OpAlloc) begin
            if (idx_q + 1'b1 == wend_q || idx_q + 1'b1 == Top) begin
              st_q <= SHole; idx_q <= '0; pv_q <= 1'b0;
            end else begin
              idx_q <= idx_d; pv_q <= 1'b1;
            end
          end else if (!pv_q || (!at_end && rdata == r_q.owner_id)) begin
            if (pv_q) used_q <= used_q - 1'b1;
            idx_q <= idx_d; pv_q <= 1'b1;
          end else begin
            st_q <= SHole; idx_q <= '0; pv_q <= 1'b0;
          end
        end
        SHole: begin
          idx_q <= idx_d;
          pv_q <= 1'b1;
          if (!pv_q) begin holes_q <= '0; prev_free_q <= 1'b0; end
          else begin
            prev_free_q <= free_u;
            if (prev_free_q && !free_u) holes_q <= holes_q + 1'b1;
            if (at_end) st_q <= SOut;
          end
        end
        SOut: begin
          if (!out_v_q) begin
            out_q.status <= stat_q;
            out_q.start_address <= AddrOutW'(pick_q);
            out_q.hole_count <= holes_q;
            out_q.used_units <= UsedW'(used_q);
            out_v_q <= 1'b1;
            st_q <= SIdle;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule

FILE: verif/tb.sv
// Testbench for the contiguous fit allocator core: random and directed requests
// checked against a behavioral owner map. Depends on cfa_pkg, cfa_if and the core.
class alloc_scoreboard;
  logic [7:0] owner_map [128];
  int unsigned next_ptr;
  int unsigned occupied;
  logic [1:0] fit_mode;
  cfa_pkg::rsp_t pending_rsp [$];
  int mismatches;

  function void clear();
    foreach (owner_map[i]) owner_map[i] = '0;
    next_ptr = 0;
    occupied = 0;
    fit_mode = cfa_pkg::FitFirst;
    mismatches = 0;
  endfunction

  function int unsigned count_holes();
    int unsigned n;
    n = 0;
    for (int i = 0; i < 128; i++)
      if (owner_map[i] == 0 && (i == 127 || owner_map[i+1] != 0)) n++;
    return n;
  endfunction

  function bit scan_from(int unsigned from, int unsigned size, output int unsigned start);
    int unsigned run;
    run = 0;
    start = 0;
    for (int unsigned i = from; i < 128; i++) begin
      run = (owner_map[i] == 0) ? run + 1 : 0;
      if (run >= size) begin
        start = i + 1 - size;
        return 1;
      end
    end
    return 0;
  endfunction

  function bit scan_holes(int unsigned size, output int unsigned start);
    bit found;
    int unsigned pick, pick_len, run;
    found = 0; pick = 0; pick_len = 0; run = 0;
    for (int unsigned i = 0; i <= 128; i++) begin
      if (i < 128 && owner_map[i] == 0) begin
        run++;
      end else begin
        if (run >= size && run > 0) begin
          if (fit_mode == cfa_pkg::FitFirst) begin
            start = i - run;
            return 1;
          end
          if (!found || (fit_mode == cfa_pkg::FitBest && run <= pick_len) ||
              (fit_mode == cfa_pkg::FitWorst && run >= pick_len)) begin
            found = 1;
            pick = i - run;
            pick_len = run;
          end
        end
        run = 0;
      end
    end
    start = pick;
    return found;
  endfunction

  // Applies one accepted request to the map and queues its expected result.
  function void note_request(cfa_pkg::req_t rq);
    cfa_pkg::rsp_t r;
    int unsigned start, size, holes;
    bit ok;
    start = 0;
    ok = 0;
    size = rq.request_size;
    r.status = cfa_pkg::StDone;
    if (rq.operation == cfa_pkg::OpAlloc) begin
      if (rq.owner_id != 0 && size != 0 && size <= 128) begin
        if (fit_mode == cfa_pkg::FitNext) begin
          ok = scan_from(next_ptr, size, start);
          if (!ok) ok = scan_from(0, size, start);
          if (ok) next_ptr = start + size;
        end else begin
          ok = scan_holes(size, start);
        end
      end
      if (ok) begin
        for (int unsigned i = start; i < start + size && i < 128; i++)
          owner_map[i] = rq.owner_id;
        occupied += size;
      end else begin
        r.status = cfa_pkg::StNoHole;
        start = 0;
      end
    end else begin
      if (rq.owner_id != 0)
        for (int unsigned i = 0; i < 128; i++)
          if (owner_map[i] == rq.owner_id) begin
            ok = 1;
            start = i;
            break;
          end
      if (ok) begin
        for (int unsigned i = start; i < 128 && owner_map[i] == rq.owner_id; i++) begin
          owner_map[i] = 0;
          occupied--;
        end
      end else begin
        r.status = cfa_pkg::StNotFound;
        start = 0;
      end
    end
    holes = count_holes();
    r.start_address = start[6:0];
    r.hole_count = holes[6:0];
    r.used_units = occupied[7:0];
    pending_rsp.push_back(r);
  endfunction

  function void check_result(cfa_pkg::rsp_t got);
    cfa_pkg::rsp_t want;
    if (pending_rsp.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    want = pending_rsp.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

module tb;
  import cfa_pkg::*;

  localparam int IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = FitFirst;
  logic hold_off = 1'b0;
  int idle_cycles = 0;

  cfa_req_if req_ch();
  cfa_rsp_if rsp_ch();
  alloc_scoreboard alloc_sb;

  contiguous_fit_allocator_core i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    alloc_sb = new();
    alloc_sb.clear();
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
  end

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
  endfunction

  // Result side: random stalls, plus a long hold-off while hold_off is set.
  always @(posedge clk_i) begin
    if (rsp_ch.valid && rsp_ch.ready) alloc_sb.check_result(rsp_ch.data);
    if (req_ch.valid && req_ch.ready || rsp_ch.valid && rsp_ch.ready) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int unsigned g;
    @(negedge clk_i);
    forever begin
      if (hold_off) begin
        rsp_ch.ready <= 1'b0;
        @(negedge clk_i);
      end else begin
        g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
        rsp_ch.ready <= (g == 0);
        repeat (g == 0 ? 1 : g) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i)
    if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end

  // Offers one item and returns at the falling edge after it is accepted,
  // with valid still high so that the next item can follow directly.
  task automatic send_request(logic op, logic [7:0] id, logic [7:0] size);
    req_ch.valid <= 1'b1;
    req_ch.data <= '{operation: op, owner_id: id, request_size: size};
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    alloc_sb.note_request(req_ch.data);
    @(negedge clk_i);
  endtask

  task automatic send_with_gap(logic op, logic [7:0] id, logic [7:0] size);
    int unsigned g;
    g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (g != 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    send_request(op, id, size);
  endtask

  task automatic drain_and_set_mode(logic [1:0] mode);
    req_ch.valid <= 1'b0;
    while (alloc_sb.pending_rsp.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    alloc_sb.fit_mode = mode;
  endtask

  // Mostly allocates of small runs and frees of owners 1 to 24; a few odd requests.
  task automatic random_phase(int n);
    logic [7:0] id, size;
    logic op;
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      op = (k < 50) ? OpAlloc : OpFree;
      id = (k < 90) ? 8'($urandom_range(1, 24)) : 8'($urandom_range(0, 255));
      if (k >= 95) size = 8'($urandom_range(0, 255));
      else if (k >= 85) size = 8'($urandom_range(1, 128));
      else size = 8'($urandom_range(1, 20));
      send_with_gap(op, id, size);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    // Directed: extremes, owner zero, bad sizes, duplicates, unknown frees.
    send_request(OpAlloc, 8'd0, 8'd4);
    send_request(OpFree, 8'd0, 8'd1);
    send_request(OpAlloc, 8'd5, 8'd0);
    send_request(OpAlloc, 8'd5, 8'd129);
    send_request(OpAlloc, 8'd5, 8'd255);
    send_request(OpAlloc, 8'd255, 8'd128);
    send_request(OpAlloc, 8'd1, 8'd1);
    send_request(OpFree, 8'd255, 8'd0);
    send_request(OpFree, 8'd200, 8'd9);
    send_request(OpAlloc, 8'd1, 8'd10);
    send_request(OpAlloc, 8'd2, 8'd20);
    send_request(OpAlloc, 8'd1, 8'd5);
    send_request(OpAlloc, 8'd3, 8'd30);
    send_request(OpFree, 8'd1, 8'd0);
    send_request(OpFree, 8'd1, 8'd0);
    drain_and_set_mode(FitBest);
    send_request(OpAlloc, 8'd4, 8'd3);
    drain_and_set_mode(FitWorst);
    send_request(OpAlloc, 8'd6, 8'd2);
    drain_and_set_mode(FitNext);
    send_request(OpAlloc, 8'd7, 8'd60);
    send_request(OpAlloc, 8'd8, 8'd12);
    send_request(OpAlloc, 8'd9, 8'd4);
    // The sender keeps offering while the receiver holds off.
    hold_off <= 1'b1;
    fork
      begin
        repeat (2000) @(negedge clk_i);
        hold_off <= 1'b0;
      end
      random_phase(6);
    join
    for (int p = 0; p < 8; p++) begin
      drain_and_set_mode(p[1:0]);
      random_phase(85);
    end
    drain_and_set_mode(FitFirst);
    while (alloc_sb.pending_rsp.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (alloc_sb.mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
